/* rtl/erpd_pkg.sv */
package erpd_pkg;

    localparam int TICK_W     = 18;
    localparam int DIST_W     = 18;
    localparam int SCORE_W    = 17;
    localparam int DIV_W      = 13;
    localparam int BAND_W     = 8;
    localparam int LIMIT_W    = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd2;

    localparam logic [DIV_W-1:0]   DIVIDER_RST = 13'd105;
    localparam logic [BAND_W-1:0]  BAND_RST    = 8'd10;
    localparam logic [LIMIT_W-1:0] LIMIT_RST   = 18'd130000;

    typedef struct packed {
        logic [DIV_W-1:0]   divider_mm;
        logic [BAND_W-1:0]  band_mm;
        logic [LIMIT_W-1:0] echo_limit;
    } t_cfg;

endpackage

/* rtl/echo_range_presence_detector.sv */
// Echo range presence detector. Each input word is one echo width in 4 MHz ticks; widths
// at or above echo_limit are rejected and leave all state alone. Accepted widths become a
// distance in 1/2**FRAC_BITS mm, feed an exponential running average (0.93 / 0.07), update
// a best score (divider minus average, cleared only by reset) and an inside/outside flag
// with a hysteresis band around the divider; leaving "inside" raises finish. One word is
// accepted per clock while the output is not stalled, and each result word passes through
// a three-stage pipeline (distance multiply, average update, score and presence compare) to
// the output; the average feedback lies wholly within the second stage, which allows that
// rate. Configuration is always ready and must only be written while the pipeline is
// empty.
module echo_range_presence_detector
    import erpd_pkg::*;
#(
    parameter int FRAC_BITS = 4,
    parameter int COEF_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [TICK_W-1:0]     i_echo_ticks,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_accepted,
    output logic [DIST_W-1:0]     o_distance_q4,
    output logic [DIST_W-1:0]     o_average_q4,
    output logic                  o_inside_res,
    output logic                  o_finish,
    output logic [SCORE_W-1:0]    o_score_q4
);

    localparam int KD_W   = COEF_BITS + FRAC_BITS;
    localparam int DPROD_W = TICK_W + KD_W;
    localparam int EMA_W  = DIST_W + COEF_BITS + 1;
    localparam int DQ_W   = DIV_W + FRAC_BITS;
    localparam int CMP_W  = ((DQ_W > DIST_W) ? DQ_W : DIST_W) + 2;

    // 0.0425 mm per tick, 0.93 keep, remainder new
    localparam longint KD_VAL   = (64'd425 << KD_W) / 64'd10000;
    localparam longint KK_VAL   = (64'd93 << COEF_BITS) / 64'd100;
    localparam longint KN_VAL   = (64'd1 << COEF_BITS) - KK_VAL;

    localparam logic [KD_W-1:0]      K_DIST = KD_W'(KD_VAL);
    localparam logic [COEF_BITS-1:0] K_KEEP = COEF_BITS'(KK_VAL);
    localparam logic [COEF_BITS-1:0] K_NEW  = COEF_BITS'(KN_VAL);

    t_cfg w_cfg;

    erpd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    assign o_cfg_ready = 1'b1;

    // pipeline control
    logic r_s1_v, r_s2_v, r_s3_v;
    logic s1_free, s2_free, s3_free;
    logic in_acc, mv1, mv2;

    assign s3_free    = !r_s3_v || i_out_ready;
    assign s2_free    = !r_s2_v || s3_free;
    assign s1_free    = !r_s1_v || s2_free;
    assign o_in_ready = s1_free;
    assign in_acc     = i_in_valid && s1_free;
    assign mv1        = r_s1_v && s2_free;
    assign mv2        = r_s2_v && s3_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_v <= 1'b1;
            end else if (mv1) begin
                r_s1_v <= 1'b0;
            end
            if (mv1) begin
                r_s2_v <= 1'b1;
            end else if (mv2) begin
                r_s2_v <= 1'b0;
            end
            if (mv2) begin
                r_s3_v <= 1'b1;
            end else if (i_out_ready) begin
                r_s3_v <= 1'b0;
            end
        end
    end

    // stage 1: range check and tick-to-distance scaling
    logic [DPROD_W-1:0] dist_prod;
    logic               r_s1_acc;
    logic [DIST_W-1:0]  r_s1_dist;

    assign dist_prod = DPROD_W'(i_echo_ticks) * DPROD_W'(K_DIST);

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_acc  <= (i_echo_ticks < w_cfg.echo_limit);
            r_s1_dist <= dist_prod[COEF_BITS +: DIST_W];
        end
    end

    // stage 2: running average
    logic [DIST_W-1:0] r_avg, r_last;
    logic [EMA_W-1:0]  ema_sum;
    logic [DIST_W-1:0] n_avg;
    logic              r_s2_acc;
    logic [DIST_W-1:0] r_s2_avg, r_s2_last;

    assign ema_sum = EMA_W'(r_avg) * EMA_W'(K_KEEP) + EMA_W'(r_s1_dist) * EMA_W'(K_NEW);
    assign n_avg   = ema_sum[COEF_BITS +: DIST_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg  <= '0;
            r_last <= '0;
        end else if (mv1 && r_s1_acc) begin
            r_avg  <= n_avg;
            r_last <= r_s1_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv1) begin
            r_s2_acc  <= r_s1_acc;
            r_s2_avg  <= r_s1_acc ? n_avg : r_avg;
            r_s2_last <= r_s1_acc ? r_s1_dist : r_last;
        end
    end

    // stage 3: score and presence with hysteresis, output register
    logic [CMP_W-1:0]   div_q, band_q, avg_w, diff;
    logic               score_up, go_in, go_out;
    logic               r_presence;
    logic [SCORE_W-1:0] r_score;
    logic               r_s3_acc, r_s3_fin;
    logic [DIST_W-1:0]  r_s3_dist, r_s3_avg;

    assign div_q    = CMP_W'(w_cfg.divider_mm) << FRAC_BITS;
    assign band_q   = CMP_W'(w_cfg.band_mm) << FRAC_BITS;
    assign avg_w    = CMP_W'(r_s2_avg);
    assign diff     = div_q - avg_w;
    assign score_up = div_q > (avg_w + CMP_W'(r_score));
    assign go_in    = !r_presence && ((avg_w + band_q) < div_q);
    assign go_out   = r_presence && (avg_w > (div_q + band_q));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_presence <= 1'b0;
            r_score    <= '0;
        end else if (mv2 && r_s2_acc) begin
            if (score_up) begin
                r_score <= diff[SCORE_W-1:0];
            end
            if (go_in) begin
                r_presence <= 1'b1;
            end else if (go_out) begin
                r_presence <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv2) begin
            r_s3_acc  <= r_s2_acc;
            r_s3_fin  <= r_s2_acc && go_out;
            r_s3_dist <= r_s2_last;
            r_s3_avg  <= r_s2_avg;
        end
    end

    assign o_out_valid   = r_s3_v;
    assign o_accepted    = r_s3_acc;
    assign o_distance_q4 = r_s3_dist;
    assign o_average_q4  = r_s3_avg;
    assign o_inside_res  = r_presence;
    assign o_finish      = r_s3_fin;
    assign o_score_q4    = r_score;

endmodule

/* rtl/erpd_cfg.sv */
module erpd_cfg
    import erpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.divider_mm <= DIVIDER_RST;
            r_cfg.band_mm    <= BAND_RST;
            r_cfg.echo_limit <= LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DIVIDER: r_cfg.divider_mm <= i_cfg_data[DIV_W-1:0];
                CFG_BAND:    r_cfg.band_mm    <= i_cfg_data[BAND_W-1:0];
                CFG_LIMIT:   r_cfg.echo_limit <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* dv/tb_echo_range_presence_detector.sv */
`timescale 1ns / 100ps

module tb_echo_range_presence_detector;
    import erpd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam longint unsigned TICK_TO_Q4 = 44564;
    localparam longint unsigned EMA_KEEP_W = 60948;
    localparam longint unsigned EMA_NEW_W  = 4588;
    localparam int              COEF_SHIFT = 16;
    localparam int              Q_SHIFT    = 4;
    localparam longint          TICK_MAX   = 262143;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int N_PHASES     = 8;

    typedef struct packed {
        logic               accepted;
        logic [DIST_W-1:0]  dist_q4;
        logic [DIST_W-1:0]  avg;
        logic               in_flag;
        logic               fin;
        logic [SCORE_W-1:0] score;
    } t_echo_rpt;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [TICK_W-1:0]     i_echo_ticks;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_accepted;
    logic [DIST_W-1:0]     o_distance_q4;
    logic [DIST_W-1:0]     o_average_q4;
    logic                  o_inside_res;
    logic                  o_finish;
    logic [SCORE_W-1:0]    o_score_q4;

    echo_range_presence_detector uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_echo_ticks  (i_echo_ticks),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_accepted    (o_accepted),
        .o_distance_q4 (o_distance_q4),
        .o_average_q4  (o_average_q4),
        .o_inside_res  (o_inside_res),
        .o_finish      (o_finish),
        .o_score_q4    (o_score_q4)
    );

    // echo widths waiting to be sent, and reports owed by the block
    logic [TICK_W-1:0] echo_tx_q[$];
    t_echo_rpt         range_rpt_q[$];

    // predicted configuration and tracker state
    logic [DIV_W-1:0]   div_mm;
    logic [BAND_W-1:0]  half_band_mm;
    logic [LIMIT_W-1:0] limit_ticks;
    logic [DIST_W-1:0]  est_dist;
    logic [DIST_W-1:0]  est_avg;
    logic               est_inside;
    logic [SCORE_W-1:0] est_score;

    int          bad_words;
    int          idle_cycles;
    int          burst_left;
    int          gap_left;
    int unsigned cyc;

    logic [CFG_DATA_W-1:0] ph_div[N_PHASES];
    logic [CFG_DATA_W-1:0] ph_band[N_PHASES];
    logic [CFG_DATA_W-1:0] ph_limit[N_PHASES];

    function automatic t_echo_rpt track_echo(input logic [TICK_W-1:0] ticks);
        t_echo_rpt       r;
        longint unsigned dist64;
        longint unsigned avg64;
        longint          thr_q;
        longint          lo_q;
        longint          hi_q;
        longint          gap_q;
        r.accepted = 1'b0;
        r.fin      = 1'b0;
        if (ticks < limit_ticks) begin
            dist64   = (longint'(ticks) * TICK_TO_Q4) >> COEF_SHIFT;
            avg64    = (longint'(est_avg) * EMA_KEEP_W + dist64 * EMA_NEW_W) >> COEF_SHIFT;
            est_dist = dist64[DIST_W-1:0];
            est_avg  = avg64[DIST_W-1:0];
            thr_q    = longint'(div_mm) <<< Q_SHIFT;
            lo_q     = thr_q - (longint'(half_band_mm) <<< Q_SHIFT);
            hi_q     = thr_q + (longint'(half_band_mm) <<< Q_SHIFT);
            gap_q    = thr_q - longint'(est_avg);
            if (gap_q > longint'(est_score))
                est_score = gap_q[SCORE_W-1:0];
            if (!est_inside) begin
                if (longint'(est_avg) < lo_q)
                    est_inside = 1'b1;
            end else if (longint'(est_avg) > hi_q) begin
                est_inside = 1'b0;
                r.fin      = 1'b1;
            end
            r.accepted = 1'b1;
        end
        r.dist_q4 = est_dist;
        r.avg     = est_avg;
        r.in_flag = est_inside;
        r.score   = est_score;
        return r;
    endfunction

    function automatic longint mm_to_ticks(input longint mm);
        longint t;
        t = (mm * 16 * 65536) / longint'(TICK_TO_Q4);
        if (t < 0)
            t = 0;
        if (t > TICK_MAX)
            t = TICK_MAX;
        return t;
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0]  idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            CFG_DIVIDER: div_mm       = data[DIV_W-1:0];
            CFG_BAND:    half_band_mm = data[BAND_W-1:0];
            CFG_LIMIT:   limit_ticks  = data[LIMIT_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained;
        do
            @(posedge i_clk);
        while (echo_tx_q.size() != 0 || i_in_valid || range_rpt_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // mostly runs that settle the average just below or just above the band, plus noise
    task automatic queue_echo_runs(input int n_items);
        int     added;
        int     len;
        int     pick;
        longint target_mm;
        longint base;
        longint t;
        added = 0;
        while (added < n_items) begin
            pick = $urandom_range(0, 9);
            len  = 1;
            if (pick < 7) begin
                len       = $urandom_range(10, 35);
                target_mm = longint'(half_band_mm) + $urandom_range(1, 30);
                target_mm = $urandom_range(0, 1) ? longint'(div_mm) + target_mm
                                                 : longint'(div_mm) - target_mm;
                if (target_mm < 0)
                    target_mm = $urandom_range(0, 5);
                base = mm_to_ticks(target_mm);
                for (int k = 0; k < len; k++) begin
                    t = base + $urandom_range(0, 40) - 20;
                    if (t < 0)
                        t = 0;
                    if (t > TICK_MAX)
                        t = TICK_MAX;
                    echo_tx_q.push_back(t[TICK_W-1:0]);
                end
            end else if (pick == 7) begin
                len = $urandom_range(1, 4);
                repeat (len) echo_tx_q.push_back(TICK_W'($urandom_range(0, TICK_MAX)));
            end else if (pick == 8) begin
                len = $urandom_range(1, 3);
                repeat (len)
                    echo_tx_q.push_back(TICK_W'($urandom_range(limit_ticks, TICK_MAX)));
            end else begin
                len = $urandom_range(1, 3);
                repeat (len) echo_tx_q.push_back(TICK_W'($urandom_range(0, 15)));
            end
            added += len;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // sender: bursts of random length separated by random gaps
    always @(posedge i_clk) begin : echo_driver
        logic              nxt_valid;
        logic [TICK_W-1:0] nxt_ticks;
        nxt_valid = i_in_valid;
        nxt_ticks = i_echo_ticks;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                range_rpt_q.push_back(track_echo(i_echo_ticks));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (echo_tx_q.size() != 0) begin
                    nxt_valid = 1'b1;
                    nxt_ticks = echo_tx_q.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 16);
                        // keep long stretches free of gaps
                        gap_left = (cyc[9:8] == 2'd3 || $urandom_range(0, 3) == 0)
                                   ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
        i_in_valid   <= nxt_valid;
        i_echo_ticks <= nxt_ticks;
    end

    // receiver: check each word against the oldest prediction, stall on a rotating pattern
    always @(posedge i_clk) begin : report_monitor
        t_echo_rpt got;
        t_echo_rpt want;
        logic      rdy;
        cyc++;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_accepted, o_distance_q4, o_average_q4, o_inside_res, o_finish,
                    o_score_q4};
            if (range_rpt_q.size() == 0) begin
                bad_words++;
                if (bad_words <= 10)
                    $display("unexpected result word: acc %0d dist %0d avg %0d",
                             got.accepted, got.dist_q4, got.avg,
                             " in %0d fin %0d score %0d",
                             got.in_flag, got.fin, got.score);
            end else begin
                want = range_rpt_q.pop_front();
                if (got.accepted !== want.accepted || got.dist_q4 !== want.dist_q4 ||
                    got.avg !== want.avg || got.in_flag !== want.in_flag ||
                    got.fin !== want.fin || got.score !== want.score) begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display("mismatch (exp/got): acc %0d/%0d dist %0d/%0d",
                                 want.accepted, got.accepted, want.dist_q4, got.dist_q4,
                                 " avg %0d/%0d in %0d/%0d",
                                 want.avg, got.avg, want.in_flag, got.in_flag,
                                 " fin %0d/%0d score %0d/%0d",
                                 want.fin, got.fin, want.score, got.score);
                end
            end
        end
        case (cyc[9:8])
            2'd0:    rdy = 1'b1;
            2'd1:    rdy = ($urandom_range(0, 9) > 2);
            2'd2:    rdy = (cyc[3:0] < 4'd5);
            default: rdy = cyc[1];
        endcase
        i_out_ready <= rdy;

        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout with %0d words owed", range_rpt_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        div_mm       = DIVIDER_RST;
        half_band_mm = BAND_RST;
        limit_ticks  = LIMIT_RST;
        est_dist     = '0;
        est_avg      = '0;
        est_inside   = 1'b0;
        est_score    = '0;
        bad_words    = 0;
        idle_cycles  = 0;
        burst_left   = 0;
        gap_left     = 0;
        cyc          = 0;
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_echo_ticks = '0;
        i_out_ready  = 1'b0;

        // divider overflow with masked upper bits, minimum limit, band above divider,
        // top of range, limit of zero, then random settings
        ph_div[0] = '1;    ph_band[0] = '1;   ph_limit[0] = '1;
        ph_div[1] = 18'd0; ph_band[1] = 18'd0; ph_limit[1] = 18'd1;
        ph_div[2] = 18'd5; ph_band[2] = 18'd200; ph_limit[2] = 18'd262143;
        ph_div[3] = 18'd6000; ph_band[3] = 18'd255; ph_limit[3] = 18'd200000;
        ph_div[4] = 18'd105; ph_band[4] = 18'd10; ph_limit[4] = 18'd0;
        for (int p = 5; p < N_PHASES; p++) begin
            ph_div[p]   = CFG_DATA_W'($urandom_range(20, 600));
            ph_band[p]  = CFG_DATA_W'($urandom_range(0, 40));
            ph_limit[p] = CFG_DATA_W'($urandom_range(20000, 262143));
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // settle inside, then pull away far enough to leave and raise finish
        repeat (3) echo_tx_q.push_back(18'd1500);
        repeat (8) echo_tx_q.push_back(18'd8000);
        echo_tx_q.push_back(18'd0);
        echo_tx_q.push_back(18'd1);
        echo_tx_q.push_back(18'd129999);
        echo_tx_q.push_back(18'd130000);
        echo_tx_q.push_back(18'h3FFFF);
        echo_tx_q.push_back(18'h15555);
        echo_tx_q.push_back(18'h2AAAA);
        wait_drained();

        // unused register index must leave the settings alone
        cfg_write(CFG_UNUSED, '1);
        for (int p = 0; p < N_PHASES; p++) begin
            cfg_write(CFG_DIVIDER, ph_div[p]);
            cfg_write(CFG_BAND, ph_band[p]);
            cfg_write(CFG_LIMIT, ph_limit[p]);
            queue_echo_runs((p == 4) ? 30 : 85);
            wait_drained();
        end

        if (bad_words == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
